// ----- rtl/srrr_pkg.sv -----
package srrr_pkg;

  localparam int WINDOW_DEF   = 32;
  localparam int SEQ_BITS_DEF = 16;
  localparam int OUT_SEQ_W    = 16;

  typedef enum logic [1:0] {
    ST_DELIVERED = 2'd0,
    ST_HELD      = 2'd1,
    ST_DISCARDED = 2'd2,
    ST_BEYOND    = 2'd3
  } rx_status_t;

  typedef enum logic {
    S_IDLE,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;   // take the input number and classify it
    logic step;   // drain the next held number
  } dp_cmd_t;

  typedef struct packed {
    logic last;   // result in the output register is the final one
  } dp_stat_t;

endpackage

// ----- rtl/srrr_ctrl.sv -----
module srrr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  srrr_pkg::dp_stat_t stat,
  output srrr_pkg::dp_cmd_t  cmd
);
  import srrr_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready && stat.last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_OUT: begin
        out_valid = 1'b1;
        cmd.step  = out_ready && !stat.last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/srrr_datapath.sv -----
module srrr_datapath #(
  parameter int WINDOW   = srrr_pkg::WINDOW_DEF,
  parameter int SEQ_BITS = srrr_pkg::SEQ_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srrr_pkg::dp_cmd_t             cmd,
  output srrr_pkg::dp_stat_t            stat,
  input  logic [15:0]                   seq_num,
  output logic [1:0]                    status,
  output logic                          delivered_valid,
  output logic [srrr_pkg::OUT_SEQ_W-1:0] delivered_seq,
  output logic                          ack_valid,
  output logic [srrr_pkg::OUT_SEQ_W-1:0] ack_seq,
  output logic                          last
);
  import srrr_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);

  // window state
  logic [SEQ_BITS-1:0] expected_seq;
  logic [SEQ_BITS-1:0] expected_seq_next;
  logic                started;
  logic                started_next;
  logic [WINDOW-1:0]   held_map;
  logic [WINDOW-1:0]   held_map_next;

  // result register
  rx_status_t            res_status;
  rx_status_t            res_status_next;
  logic                  res_dvalid;
  logic                  res_dvalid_next;
  logic [OUT_SEQ_W-1:0]  res_dseq;
  logic [OUT_SEQ_W-1:0]  res_dseq_next;
  logic                  res_avalid;
  logic                  res_avalid_next;
  logic [OUT_SEQ_W-1:0]  res_aseq;
  logic [OUT_SEQ_W-1:0]  res_aseq_next;
  logic                  res_last;
  logic                  res_last_next;

  logic [SEQ_BITS-1:0] seq;
  logic [SEQ_BITS-1:0] offset;
  logic [SEQ_BITS-1:0] cur;
  logic [WINDOW-1:0]   map_shift;
  logic                deliver;

  assign seq       = SEQ_BITS'(seq_num);
  assign offset    = seq - expected_seq;
  assign deliver   = cmd.step || (cmd.load && (offset == '0));
  assign cur       = cmd.step ? expected_seq : seq;
  assign map_shift = held_map >> 1;

  always_comb begin
    expected_seq_next = expected_seq;
    started_next      = started;
    held_map_next     = held_map;
    res_status_next   = res_status;
    res_dvalid_next   = res_dvalid;
    res_dseq_next     = res_dseq;
    res_avalid_next   = res_avalid;
    res_aseq_next     = res_aseq;
    res_last_next     = res_last;
    if (deliver) begin
      expected_seq_next = cur + SEQ_BITS'(1);
      started_next      = 1'b1;
      held_map_next     = map_shift;
      res_status_next   = ST_DELIVERED;
      res_dvalid_next   = 1'b1;
      res_dseq_next     = OUT_SEQ_W'(cur);
      res_avalid_next   = 1'b1;
      res_aseq_next     = OUT_SEQ_W'(cur);
      res_last_next     = !map_shift[0];
    end else if (cmd.load) begin
      res_dvalid_next = 1'b0;
      res_dseq_next   = '0;
      res_avalid_next = started;
      res_aseq_next   = started ? OUT_SEQ_W'(expected_seq - SEQ_BITS'(1)) : '0;
      res_last_next   = 1'b1;
      if (offset[SEQ_BITS-1]) begin
        res_status_next = ST_DISCARDED;
      end else if (offset < SEQ_BITS'(WINDOW)) begin
        held_map_next[offset[IDX_W-1:0]] = 1'b1;
        res_status_next = ST_HELD;
      end else begin
        res_status_next = ST_BEYOND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq <= '0;
      started      <= 1'b0;
      held_map     <= '0;
    end else begin
      expected_seq <= expected_seq_next;
      started      <= started_next;
      held_map     <= held_map_next;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_dvalid <= res_dvalid_next;
    res_dseq   <= res_dseq_next;
    res_avalid <= res_avalid_next;
    res_aseq   <= res_aseq_next;
    res_last   <= res_last_next;
  end

  assign stat.last       = res_last;
  assign status          = res_status;
  assign delivered_valid = res_dvalid;
  assign delivered_seq   = res_dseq;
  assign ack_valid       = res_avalid;
  assign ack_seq         = res_aseq;
  assign last            = res_last;

endmodule

// ----- rtl/selective_repeat_reorder_receiver_top.sv -----
// Selective-repeat receive window with in-order delivery.
//
// Input channel (in_valid/in_ready, seq_num): one arriving sequence number per
// transfer, taken modulo 2^SEQ_BITS. Output channel (out_valid/out_ready):
// one result per transfer with status, the delivered number when there is one,
// the cumulative ack, and last on the final result caused by the input.
//
// The first result is valid in the cycle after the input transfer.
// An input causing R results is taken while the controller is idle; the
// results then follow one per cycle while out_ready is high, all through a
// single output register. Held numbers that become consecutive are drained
// one per cycle from the bitmap under out_ready, R ranging from 1 to WINDOW.
// in_ready is high only while no result is pending.
//
// Reset (rst, synchronous): expected number 0, nothing delivered, bitmap
// empty, controller idle with in_ready high.
//
// A stalled receiver (out_ready low) simply holds the current result; no
// drain step or new input is taken until it is transferred.
module selective_repeat_reorder_receiver_top #(
  parameter int WINDOW   = srrr_pkg::WINDOW_DEF,
  parameter int SEQ_BITS = srrr_pkg::SEQ_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [15:0]                    seq_num,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic                           delivered_valid,
  output logic [srrr_pkg::OUT_SEQ_W-1:0] delivered_seq,
  output logic                           ack_valid,
  output logic [srrr_pkg::OUT_SEQ_W-1:0] ack_seq,
  output logic                           last
);
  import srrr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // handshake sequencing
  srrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // window state, classification and result register
  srrr_datapath #(
    .WINDOW   (WINDOW),
    .SEQ_BITS (SEQ_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .seq_num         (seq_num),
    .status          (status),
    .delivered_valid (delivered_valid),
    .delivered_seq   (delivered_seq),
    .ack_valid       (ack_valid),
    .ack_seq         (ack_seq),
    .last            (last)
  );

endmodule
